// ----- rtl/clt_pkg.sv -----
// Shared types and codes for the caching lock client table.
// Request and response beats, table entry layout and the per-event update.
// No dependencies.
`default_nettype none
package clt_pkg;

   localparam int CLT_NUM_LOCKS = 64;
   localparam int CMD_W         = 3;
   localparam int ID_W          = 6;
   localparam int ACT_W         = 3;
   localparam int STATE_W       = 3;

   localparam logic [CMD_W-1:0] CMD_ACQUIRE       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE_REPLY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REVOKE        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RETRY_GRANT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RELEASE_DONE  = 3'd5;

   localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_GRANTED   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WAIT      = 3'd2;
   localparam logic [ACT_W-1:0] ACT_SEND_ACQ  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SEND_REL  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_NOT_FOUND = 3'd5;

   localparam logic [STATE_W-1:0] ST_NONE      = 3'd0;
   localparam logic [STATE_W-1:0] ST_FREE      = 3'd1;
   localparam logic [STATE_W-1:0] ST_LOCKED    = 3'd2;
   localparam logic [STATE_W-1:0] ST_ACQUIRING = 3'd3;
   localparam logic [STATE_W-1:0] ST_RELEASING = 3'd4;
   localparam logic [STATE_W-1:0] ST_RETRY     = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ID_W-1:0]  lock_id;
      logic             reply_ok;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             wake_waiters;
      logic [ID_W-1:0]  lock_out;
   } rsp_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic               revoked;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      entry_type        entry;
      logic [ACT_W-1:0] action;
      logic             wake;
   } upd_type;

endpackage
`default_nettype wire

// ----- rtl/caching_lock_client_table.sv -----
// Caching lock client table: one event in, one action out.
// Path: an accepted beat is registered into stage one, then its response into the rsp_valid/rsp_beat registers.
// Throughput: one beat per cycle; busy stays low, the table RAM read and write ports set the pace.
// Reset: synchronous, clears all known bits, so every lock reads as unknown; no clearing pass.
// The receiver cannot stall: each response is on rsp_beat for exactly one cycle.
`default_nettype none
module caching_lock_client_table
   import clt_pkg::*;
#(
   parameter int NUM_LOCKS = CLT_NUM_LOCKS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_beat,
   output logic         rsp_valid,
   output rsp_type      rsp_beat
);

   localparam int DEPTH = (NUM_LOCKS < (1 << ID_W)) ? NUM_LOCKS : (1 << ID_W);
   localparam int IDX_W = $clog2(DEPTH);

   logic                  accept;
   logic                  s1_valid_ff;
   req_type               s1_req_ff;
   logic [IDX_W-1:0]      s1_idx;
   logic                  s1_in_range;
   logic [DEPTH-1:0]      known_ff;
   logic [DEPTH-1:0]      known_in;
   logic                  byp_valid_ff;
   logic [IDX_W-1:0]      byp_idx_ff;
   entry_type             byp_entry_ff;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             cur_entry;
   upd_type               upd;
   logic                  do_write;
   logic                  rsp_valid_ff;
   rsp_type               rsp_beat_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign s1_idx      = s1_req_ff.lock_id[IDX_W-1:0];
   assign s1_in_range = 32'(s1_req_ff.lock_id) < NUM_LOCKS;
   assign cur_entry   = (byp_valid_ff && byp_idx_ff == s1_idx) ? byp_entry_ff
                                                               : entry_type'(ram_rdata);
   assign do_write    = s1_valid_ff & upd.we;

   clt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (do_write),
      .waddr (s1_idx),
      .wdata (upd.entry),
      .raddr (req_beat.lock_id[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   clt_decide u_decide (
      .command  (s1_req_ff.command),
      .reply_ok (s1_req_ff.reply_ok),
      .in_range (s1_in_range),
      .known    (known_ff[s1_idx]),
      .entry    (cur_entry),
      .upd      (upd)
   );

   always_comb begin
      known_in = known_ff;
      if (do_write) begin
         known_in[s1_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         known_ff     <= '0;
      end else begin
         s1_valid_ff  <= accept;
         byp_valid_ff <= do_write;
         rsp_valid_ff <= s1_valid_ff;
         known_ff     <= known_in;
      end
      s1_req_ff             <= req_beat;
      byp_idx_ff            <= s1_idx;
      byp_entry_ff          <= upd.entry;
      rsp_beat_ff.action       <= upd.action;
      rsp_beat_ff.wake_waiters <= upd.wake;
      rsp_beat_ff.lock_out     <= s1_req_ff.lock_id;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

`ifndef ASSERT_OFF
   a_rsp_follows_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(s1_valid_ff))
      else $error("response strobe out of step with stage one");

   a_rsp_lock_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.lock_out == $past(req_beat.lock_id, 2))
      else $error("response lock index does not match accepted beat");

   a_no_wake_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_beat.action == ACT_NOT_FOUND && rsp_beat.wake_waiters))
      else $error("wake raised on not_found");

   a_write_marks_known: assert property (@(posedge clock) disable iff (reset)
      do_write |=> known_ff[$past(s1_idx)])
      else $error("written entry not marked known");
`endif

endmodule
`default_nettype wire

// ----- rtl/clt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module clt_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/clt_decide.sv -----
// Per-event decision: next entry, write enable, action and wake flag.
// Depends on clt_pkg.
`default_nettype none
module clt_decide
   import clt_pkg::*;
(
   input  wire logic [CMD_W-1:0] command,
   input  wire logic             reply_ok,
   input  wire logic             in_range,
   input  wire logic             known,
   input  wire entry_type        entry,
   output upd_type              upd
);

   entry_type cur;

   always_comb begin
      cur = known ? entry : entry_type'{state: ST_NONE, revoked: 1'b0};
      upd = '0;
      upd.entry  = cur;
      upd.action = ACT_NONE;
      if (!in_range) begin
         upd.action = ACT_NOT_FOUND;
      end else begin
         case (command)
            CMD_ACQUIRE: begin
               upd.we = 1'b1;
               if (cur.state == ST_FREE || cur.state == ST_RETRY) begin
                  upd.entry.state = ST_LOCKED;
                  upd.action      = ACT_GRANTED;
               end else if (cur.state == ST_NONE) begin
                  upd.entry.state = ST_ACQUIRING;
                  upd.action      = ACT_SEND_ACQ;
               end else begin
                  upd.action = ACT_WAIT;
               end
            end
            CMD_ACQUIRE_REPLY: begin
               upd.we = 1'b1;
               if (reply_ok || cur.state == ST_FREE || cur.state == ST_RETRY) begin
                  upd.entry.state = ST_LOCKED;
                  upd.action      = ACT_GRANTED;
               end else begin
                  upd.action = ACT_WAIT;
               end
            end
            CMD_RELEASE: begin
               if (!known) begin
                  upd.action = ACT_NOT_FOUND;
               end else if (!cur.revoked) begin
                  upd.we          = 1'b1;
                  upd.entry.state = ST_FREE;
                  upd.wake        = 1'b1;
               end else begin
                  upd.we          = 1'b1;
                  upd.entry.state = ST_RELEASING;
                  upd.action      = ACT_SEND_REL;
               end
            end
            CMD_REVOKE: begin
               upd.we = 1'b1;
               if (cur.state == ST_FREE) begin
                  upd.entry.state = ST_RELEASING;
                  upd.action      = ACT_SEND_REL;
               end else if (cur.state == ST_LOCKED || cur.state == ST_ACQUIRING ||
                            cur.state == ST_RETRY) begin
                  upd.entry.revoked = 1'b1;
               end
            end
            CMD_RETRY_GRANT: begin
               upd.we          = 1'b1;
               upd.entry.state = ST_RETRY;
               upd.wake        = 1'b1;
            end
            CMD_RELEASE_DONE: begin
               upd.we            = 1'b1;
               upd.entry.state   = ST_NONE;
               upd.entry.revoked = 1'b0;
               upd.wake          = 1'b1;
            end
            default: begin
               upd.action = ACT_NONE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
